### hdl/ffha_pkg.sv
// Shared types and codes for the first-fit heap allocator.
package ffha_pkg;

	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned BYTES_W = 27;

	localparam logic [1:0] REQ_ALLOC   = 2'd0;
	localparam logic [1:0] REQ_CALLOC  = 2'd1;
	localparam logic [1:0] REQ_FREE    = 2'd2;
	localparam logic [1:0] REQ_REALLOC = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_SIZE = 2'd1;
	localparam logic [1:0] ST_NO_SPACE = 2'd2;
	localparam logic [1:0] ST_UNKNOWN  = 2'd3;

	typedef struct packed {
		logic [ADDR_W-1:0]  start;
		logic [BYTES_W-1:0] bytes;
		logic               free;
	} tbl_entry_t;

	typedef struct packed {
		logic       en;
		tbl_entry_t data;
	} tbl_wr_t;

	typedef struct packed {
		logic               vld;
		logic               ok;
		logic [BYTES_W-1:0] need;
	} size_res_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] addr;
		logic              copy;
		logic              zero;
	} alloc_res_t;

endpackage

### hdl/ffha_table.sv
// Block table memory: one write port, one registered read port.
module ffha_table import ffha_pkg::*; #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned IW    = 6
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [IW-1:0]    rd_addr,
	output tbl_entry_t       rd_data,
	input  tbl_wr_t          wr,
	input  logic [IW-1:0]    wr_addr
);

	tbl_entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr_addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### hdl/ffha_sizer.sv
// Request sizing: element product, size check and block size with header.
module ffha_sizer import ffha_pkg::*; #(
	parameter int unsigned HEADER_BYTES = 32,
	parameter int unsigned MAX_REQUEST  = 100000000
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              calloc,
	input  logic [ADDR_W-1:0] size,
	input  logic [ADDR_W-1:0] count,
	output size_res_t         res
);

	logic                vld_s1;
	logic [2*ADDR_W-1:0] prod_s1;
	logic                vld_s2;
	logic                ok_s2;
	logic [BYTES_W-1:0]  need_s2;
	logic [2*ADDR_W:0]   sum;

	assign sum = {1'b0, prod_s1} + (2*ADDR_W+1)'(HEADER_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= calloc ? (2*ADDR_W)'(size) * (2*ADDR_W)'(count)
			                  : {{ADDR_W{1'b0}}, size};
		end
		if (vld_s1) begin
			ok_s2   <= (prod_s1 != '0) && (sum <= (2*ADDR_W+1)'(MAX_REQUEST));
			need_s2 <= sum[BYTES_W-1:0];
		end
	end

	assign res.vld  = vld_s2;
	assign res.ok   = ok_s2;
	assign res.need = need_s2;

endmodule

### hdl/ffha_ctrl.sv
// Request sequencer: table scans, grant, append and free updates.
module ffha_ctrl import ffha_pkg::*; #(
	parameter int unsigned MAX_BLOCKS   = 64,
	parameter int unsigned HEADER_BYTES = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   req_type,
	input  logic [ADDR_W-1:0]            req_addr,
	input  size_res_t                    sz,
	input  logic [ADDR_W-1:0]            limit,
	output logic                         rd_en,
	output logic [$clog2(MAX_BLOCKS)-1:0] rd_addr,
	input  tbl_entry_t                   rd_data,
	output tbl_wr_t                      wr,
	output logic [$clog2(MAX_BLOCKS)-1:0] wr_addr,
	output logic                         res_vld,
	input  logic                         res_rdy,
	output alloc_res_t                   res
);

	localparam int unsigned IW = $clog2(MAX_BLOCKS);
	localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_SIZE, S_FIND, S_GRANT, S_FREE_OLD, S_DONE
	} state_t;

	state_t             state_q;
	logic [1:0]         type_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [BYTES_W-1:0] need_q;
	logic [CW-1:0]      count_q;
	logic [ADDR_W-1:0]  top_q;
	logic [CW-1:0]      issue_q;
	logic               rd_vld_s1;
	logic [IW-1:0]      rd_idx_s1;
	logic               old_q;
	logic [IW-1:0]      old_idx_q;
	logic [ADDR_W-1:0]  old_start_q;
	logic [BYTES_W-1:0] old_bytes_q;
	alloc_res_t         res_q;

	logic               scanning;
	logic               find_hit;
	logic               fit_hit;
	logic               scan_end;
	logic               rescan;
	logic [ADDR_W:0]    grow;
	logic               room;

	assign scanning = (state_q == S_FIND) || (state_q == S_GRANT);
	assign rd_en    = scanning && (issue_q < count_q);
	assign rd_addr  = issue_q[IW-1:0];
	assign find_hit = rd_vld_s1 && (({1'b0, rd_data.start} + (ADDR_W+1)'(HEADER_BYTES))
	                                == {1'b0, addr_q});
	assign fit_hit  = rd_vld_s1 && rd_data.free && (rd_data.bytes >= need_q);
	assign scan_end = !rd_vld_s1 && (issue_q == count_q);
	assign rescan   = (state_q == S_FIND) && find_hit && (type_q != REQ_FREE)
	                  && (rd_data.bytes < need_q);
	assign grow     = {1'b0, top_q} + (ADDR_W+1)'(need_q);
	assign room     = (count_q != CW'(MAX_BLOCKS)) && (grow <= {1'b0, limit});

	always_comb begin
		wr      = '0;
		wr_addr = rd_idx_s1;
		if (state_q == S_FIND && find_hit && type_q == REQ_FREE) begin
			wr.en   = 1'b1;
			wr.data = '{start: rd_data.start, bytes: rd_data.bytes, free: 1'b1};
		end else if (state_q == S_GRANT && fit_hit) begin
			wr.en   = 1'b1;
			wr.data = '{start: rd_data.start, bytes: rd_data.bytes, free: 1'b0};
		end else if (state_q == S_GRANT && scan_end && room) begin
			wr.en   = 1'b1;
			wr.data = '{start: top_q, bytes: need_q, free: 1'b0};
			wr_addr = count_q[IW-1:0];
		end else if (state_q == S_FREE_OLD) begin
			wr.en   = 1'b1;
			wr.data = '{start: old_start_q, bytes: old_bytes_q, free: 1'b1};
			wr_addr = old_idx_q;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign res_vld  = (state_q == S_DONE);
	assign res      = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			type_q      <= REQ_ALLOC;
			addr_q      <= '0;
			need_q      <= '0;
			count_q     <= '0;
			top_q       <= '0;
			issue_q     <= '0;
			rd_vld_s1   <= 1'b0;
			rd_idx_s1   <= '0;
			old_q       <= 1'b0;
			old_idx_q   <= '0;
			old_start_q <= '0;
			old_bytes_q <= '0;
			res_q       <= '0;
		end else begin
			if (rescan) begin
				issue_q   <= '0;
				rd_vld_s1 <= 1'b0;
			end else if (scanning) begin
				if (rd_en) begin
					issue_q <= issue_q + CW'(1);
				end
				rd_vld_s1 <= rd_en;
				rd_idx_s1 <= issue_q[IW-1:0];
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						type_q  <= req_type;
						addr_q  <= req_addr;
						res_q   <= '0;
						old_q   <= 1'b0;
						state_q <= S_SIZE;
					end
				end
				S_SIZE: begin
					if (sz.vld) begin
						need_q    <= sz.need;
						issue_q   <= '0;
						rd_vld_s1 <= 1'b0;
						case (type_q)
							REQ_FREE: begin
								state_q <= (addr_q == '0) ? S_DONE : S_FIND;
							end
							REQ_REALLOC: begin
								if (!sz.ok) begin
									res_q.status <= ST_BAD_SIZE;
									state_q      <= S_DONE;
								end else begin
									state_q <= (addr_q == '0) ? S_GRANT : S_FIND;
								end
							end
							default: begin
								if (!sz.ok) begin
									res_q.status <= ST_BAD_SIZE;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_GRANT;
								end
							end
						endcase
					end
				end
				S_FIND: begin
					if (find_hit) begin
						if (type_q == REQ_FREE) begin
							state_q <= S_DONE;
						end else begin
							old_idx_q   <= rd_idx_s1;
							old_start_q <= rd_data.start;
							old_bytes_q <= rd_data.bytes;
							if (rd_data.bytes >= need_q) begin
								res_q.addr <= addr_q;
								state_q    <= S_DONE;
							end else begin
								old_q   <= 1'b1;
								state_q <= S_GRANT;
							end
						end
					end else if (scan_end) begin
						res_q.status <= ST_UNKNOWN;
						state_q      <= S_DONE;
					end
				end
				S_GRANT: begin
					if (fit_hit || (scan_end && room)) begin
						if (fit_hit) begin
							res_q.addr <= rd_data.start + ADDR_W'(HEADER_BYTES);
						end else begin
							res_q.addr <= top_q + ADDR_W'(HEADER_BYTES);
							top_q      <= grow[ADDR_W-1:0];
							count_q    <= count_q + CW'(1);
						end
						if (old_q) begin
							res_q.copy <= 1'b1;
							state_q    <= S_FREE_OLD;
						end else begin
							res_q.zero <= (type_q == REQ_CALLOC);
							state_q    <= S_DONE;
						end
					end else if (scan_end) begin
						res_q.status <= ST_NO_SPACE;
						state_q      <= S_DONE;
					end
				end
				S_FREE_OLD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_rdy) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### hdl/first_fit_heap_allocator.sv
// A plain request is sized, then scans the table of n blocks once; a move scans it twice.
// The table scan reads one entry a cycle from the block memory and sets the rate;
// a new request is taken only after the previous one has passed its result on.
// A result waits in the output register while the next request is taken.
// Reset clears block count, heap top, control state and output valid; heap_limit
// returns to 1048576. Table contents are undefined until written; no clearing pass.
module first_fit_heap_allocator import ffha_pkg::*; #(
	parameter int unsigned MAX_BLOCKS   = 64,
	parameter int unsigned HEADER_BYTES = 32,
	parameter int unsigned MAX_REQUEST  = 100000000
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [ADDR_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        req_type,
	input  logic [ADDR_W-1:0] req_size,
	input  logic [ADDR_W-1:0] req_count,
	input  logic [ADDR_W-1:0] req_addr,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [ADDR_W-1:0] result_addr,
	output logic              copy_needed,
	output logic              zero_needed
);

	localparam int unsigned IW = $clog2(MAX_BLOCKS);
	localparam logic [ADDR_W-1:0] LIMIT_RESET = 32'd1048576;

	logic [ADDR_W-1:0] limit_q;
	size_res_t         sz;
	logic              rd_en;
	logic [IW-1:0]     rd_addr;
	tbl_entry_t        rd_data;
	tbl_wr_t           wr;
	logic [IW-1:0]     wr_addr;
	logic              res_vld;
	logic              res_rdy;
	alloc_res_t        res;
	logic              out_valid_q;
	alloc_res_t        out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	ffha_sizer #(
		.HEADER_BYTES(HEADER_BYTES),
		.MAX_REQUEST (MAX_REQUEST)
	) u_sizer (
		.clk   (clk),
		.arst_n(arst_n),
		.start (in_valid && in_ready),
		.calloc(req_type == REQ_CALLOC),
		.size  (req_size),
		.count (req_count),
		.res   (sz)
	);

	ffha_table #(
		.DEPTH(MAX_BLOCKS),
		.IW   (IW)
	) u_table (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr     (wr),
		.wr_addr(wr_addr)
	);

	ffha_ctrl #(
		.MAX_BLOCKS  (MAX_BLOCKS),
		.HEADER_BYTES(HEADER_BYTES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.req_addr(req_addr),
		.sz      (sz),
		.limit   (limit_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr      (wr),
		.wr_addr (wr_addr),
		.res_vld (res_vld),
		.res_rdy (res_rdy),
		.res     (res)
	);

	assign res_rdy = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_rdy) begin
			out_valid_q <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld && res_rdy) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign result_addr = out_q.addr;
	assign copy_needed = out_q.copy;
	assign zero_needed = out_q.zero;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in progress");

	a_fail_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (result_addr == '0) && !copy_needed && !zero_needed)
		else $error("failed transaction carries a grant");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && copy_needed |-> !zero_needed && (status == ST_OK))
		else $error("copy and zero flags together");

	a_result_needs_request: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld |-> !in_ready)
		else $error("result pending while idle");

endmodule
